// ===== rtl/musb_pkg.sv =====
package musb_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DATAA = 3'd1,
    PH_DATAB = 3'd2,
    PH_SYX1  = 3'd3,
    PH_SYX2  = 3'd4
  } phase_t;

  // Code index numbers
  localparam logic [3:0] CIN_SYS_2B    = 4'h2;
  localparam logic [3:0] CIN_SYS_3B    = 4'h3;
  localparam logic [3:0] CIN_SYX_CONT  = 4'h4;
  localparam logic [3:0] CIN_SYS_1B    = 4'h5;
  localparam logic [3:0] CIN_SYX_END2  = 4'h6;
  localparam logic [3:0] CIN_SYX_END3  = 4'h7;
  localparam logic [3:0] CIN_SINGLE    = 4'hF;

  // MIDI status values
  localparam logic [7:0] ST_SYX_START  = 8'hF0;
  localparam logic [7:0] ST_MTC_QF     = 8'hF1;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4   = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5   = 8'hF5;
  localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
  localparam logic [7:0] ST_SYX_END    = 8'hF7;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;
  localparam logic [3:0] HI_PROG_CHG   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;

  typedef struct packed {
    logic [3:0] cin;
    logic [1:0] nbytes;
  } decode_t;

  // Map a status byte to its code index and data byte count
  function automatic decode_t status_decode(input logic [7:0] b);
    decode_t d;
    d.cin    = b[7:4];
    d.nbytes = 2'd2;
    if (b[7:4] == HI_PROG_CHG || b[7:4] == HI_CHAN_PRESS) begin
      d.nbytes = 2'd1;
    end else if (b[7:4] == HI_SYSTEM) begin
      case (b)
        ST_MTC_QF, ST_SONG_SEL: begin
          d.cin    = CIN_SYS_2B;
          d.nbytes = 2'd1;
        end
        ST_SONG_POS: begin
          d.cin    = CIN_SYS_3B;
          d.nbytes = 2'd2;
        end
        ST_UNDEF_F4, ST_UNDEF_F5, ST_TUNE_REQ: begin
          d.cin    = CIN_SYS_1B;
          d.nbytes = 2'd0;
        end
        default: begin
          d.cin    = CIN_SINGLE;
          d.nbytes = 2'd0;
        end
      endcase
    end
    return d;
  endfunction

endpackage

// ===== rtl/musb_if.sv =====
interface musb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface musb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cable_and_code;
  logic [7:0] status_byte;
  logic [7:0] data_byte_a;
  logic [7:0] data_byte_b;

  modport source (output valid, output cable_and_code, output status_byte,
                  output data_byte_a, output data_byte_b, input ready);
  modport sink   (input valid, input cable_and_code, input status_byte,
                  input data_byte_a, input data_byte_b, output ready);
endinterface

// ===== rtl/midi_serial_to_usb_event_packet_top.sv =====
// Serial MIDI to USB-MIDI event packet framer.
// midi_in carries one received MIDI byte per beat. packet_out carries one
// 4-byte event packet (header, status, two data bytes) per beat, produced
// when a byte completes a message; bytes that only advance the parser
// (status awaiting data, SysEx start, first SysEx byte) give no beat.
// cfg_we/cfg_wdata load the 4-bit cable number placed in the header's high
// nibble; write it only while the block is idle.
// A completing byte is captured into the held packet registers, which also
// serve as the output register, and sets the packet valid. The block takes
// one byte per cycle while the output register is free or draining; the
// phase decode and packet update sit between each accepted byte and those registers.
// A byte is taken while the output register is empty or being drained in
// the same cycle, so a stalled receiver holds the packet and pauses input.
// Reset (rst, synchronous) returns the parser to idle, clears the held
// packet bytes and the cable number, and drops any pending packet.
module midi_serial_to_usb_event_packet_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  musb_in_if.sink           midi_in,
  musb_out_if.source        packet_out
);
  import musb_pkg::*;

  logic [3:0] cable_number;
  phase_t     phase, phase_next;
  logic [1:0] data_bytes_per_message, data_bytes_per_message_next;
  logic [1:0] remaining_data, remaining_data_next;
  logic [7:0] held_header, held_header_next;
  logic [7:0] held_status, held_status_next;
  logic [7:0] held_data_a, held_data_a_next;
  logic [7:0] held_data_b, held_data_b_next;
  logic       out_valid;
  logic       emit;
  logic       in_fire;
  logic [7:0] b;
  decode_t    dec;
  logic [1:0] remaining_dec;

  assign b             = midi_in.midi_byte;
  assign in_fire       = midi_in.valid && midi_in.ready;
  assign dec           = status_decode(b);
  assign remaining_dec = remaining_data - 2'd1;

  // Take a byte while the output slot is free or draining
  assign midi_in.ready = !out_valid || packet_out.ready;

  // Hold the cable number
  always_ff @(posedge clk) begin
    if (rst) begin
      cable_number <= '0;
    end else if (cfg_we) begin
      cable_number <= cfg_wdata;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_DATAA: phase_next = (remaining_dec != 2'd0) ? PH_DATAB : PH_IDLE;
      PH_DATAB: phase_next = PH_IDLE;
      PH_SYX1:  phase_next = (b == ST_SYX_END) ? PH_IDLE : PH_SYX2;
      PH_SYX2:  phase_next = (b == ST_SYX_END) ? PH_IDLE : PH_SYX1;
      default: begin
        if (b == ST_SYX_START) begin
          phase_next = PH_SYX1;
        end else if (!b[7]) begin
          phase_next = (data_bytes_per_message == 2'd2) ? PH_DATAB : PH_IDLE;
        end else begin
          phase_next = (dec.nbytes == 2'd0) ? PH_IDLE : PH_DATAA;
        end
      end
    endcase
  end

  // Packet bytes, counts and emit decision
  always_comb begin
    emit                        = 1'b0;
    data_bytes_per_message_next = data_bytes_per_message;
    remaining_data_next         = remaining_data;
    held_header_next            = held_header;
    held_status_next            = held_status;
    held_data_a_next            = held_data_a;
    held_data_b_next            = held_data_b;
    case (phase)
      PH_DATAA: begin
        held_data_a_next    = b;
        remaining_data_next = remaining_dec;
        emit                = (remaining_dec == 2'd0);
      end
      PH_DATAB: begin
        held_data_b_next = b;
        emit             = 1'b1;
      end
      PH_SYX1: begin
        held_data_a_next = b;
        if (b == ST_SYX_END) begin
          held_header_next = {cable_number, CIN_SYX_END2};
          emit             = 1'b1;
        end
      end
      PH_SYX2: begin
        held_data_b_next = b;
        held_header_next = {cable_number,
                            (b == ST_SYX_END) ? CIN_SYX_END3 : CIN_SYX_CONT};
        emit             = 1'b1;
      end
      default: begin
        held_data_a_next = '0;
        held_data_b_next = '0;
        if (b == ST_SYX_START) begin
          held_status_next = ST_SYX_START;
        end else if (!b[7]) begin
          // running status
          held_data_a_next = b;
          emit             = (data_bytes_per_message != 2'd2);
        end else begin
          data_bytes_per_message_next = dec.nbytes;
          held_status_next            = b;
          held_header_next            = {cable_number, dec.cin};
          if (dec.nbytes == 2'd0) begin
            emit = 1'b1;
          end else begin
            remaining_data_next = dec.nbytes;
          end
        end
      end
    endcase
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                  <= PH_IDLE;
      data_bytes_per_message <= '0;
      remaining_data         <= '0;
      held_header            <= '0;
      held_status            <= '0;
      held_data_a            <= '0;
      held_data_b            <= '0;
    end else if (in_fire) begin
      phase                  <= phase_next;
      data_bytes_per_message <= data_bytes_per_message_next;
      remaining_data         <= remaining_data_next;
      held_header            <= held_header_next;
      held_status            <= held_status_next;
      held_data_a            <= held_data_a_next;
      held_data_b            <= held_data_b_next;
    end
  end

  // Hold the packet valid until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (packet_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign packet_out.valid          = out_valid;
  assign packet_out.cable_and_code = held_header;
  assign packet_out.status_byte    = held_status;
  assign packet_out.data_byte_a    = held_data_a;
  assign packet_out.data_byte_b    = held_data_b;

  // A byte in the second data phase always completes a packet
  a_datab_emits: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_DATAB |=> out_valid)
    else $error("second data byte did not produce a packet");

  // The first data phase always has a byte still due
  a_dataa_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATAA |-> remaining_data != 2'd0)
    else $error("data phase with no byte due");

  // Second SysEx byte gives a continue or three-byte end packet
  a_syx2_cin: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_SYX2 |=> out_valid &&
      (packet_out.cable_and_code[3:0] == CIN_SYX_CONT ||
       packet_out.cable_and_code[3:0] == CIN_SYX_END3))
    else $error("bad SysEx packet code");

  // SysEx start produces no packet
  a_syx_start_quiet: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && b == ST_SYX_START |=> !out_valid)
    else $error("packet produced on SysEx start");

endmodule
